FILE: rtl/ffha_pkg.sv
package ffha_pkg;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic [0:0] REG_HEAP_START = 1'b0;
	localparam logic [0:0] REG_HEAP_END = 1'b1;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_ALLOC_FAIL = 2'd1,
		ST_FREED = 2'd2,
		ST_FREE_IGNORED = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_req;    // capture the request and prepare it
		logic rd_issue;     // read entry at the walk index
		logic walk_step;    // advance the walk index
		logic shift_issue;  // move one entry during a shift
		logic insert_wr;    // write the new entry
		logic count_inc;
		logic count_dec;
		logic result_load;
		logic restore;
	} ffha_cmd_t;

	// Status returned to the controller.
	typedef struct packed {
		logic is_free;
		logic pre_fail;     // allocate rejected before walking the table
		logic walk_last;    // walk index is on the last entry
		logic fit;          // current gap fits the request
		logic carry_fail;   // a carry while walking
		logic match;        // free target found
		logic shift_done;
	} ffha_stat_t;

endpackage

FILE: rtl/ffha_if.sv
interface ffha_if #(
	parameter int unsigned W = 8
) ();
	logic valid;
	logic ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ffha_datapath.sv
module ffha_datapath #(
	parameter int unsigned MAX_BLOCKS = 64,
	parameter int unsigned WORD_BYTES = 4,
	parameter int unsigned HEADER_BYTES = 8,
	parameter int unsigned ADDR_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input ffha_pkg::ffha_cmd_t cmd,
	output ffha_pkg::ffha_stat_t stat,
	input logic cfg_we,
	input logic [0:0] cfg_idx,
	input logic [31:0] cfg_data,
	input logic in_cmd,
	input logic [31:0] in_request,
	input logic [31:0] in_release,
	output logic [31:0] res_addr,
	output logic [1:0] res_status
);
	import ffha_pkg::*;

	localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [ADDR_WIDTH:0] HDR = (ADDR_WIDTH+1)'(HEADER_BYTES);
	localparam logic [ADDR_WIDTH:0] WRD = (ADDR_WIDTH+1)'(WORD_BYTES);
	// Scaled reciprocal of WORD_BYTES; the quotient of any 32-bit request is
	// exact after the shift.
	localparam int unsigned WSH = 32 + $clog2(WORD_BYTES);
	localparam logic [32:0] RECIP =
		33'(((64'd1 << WSH) + 64'(WORD_BYTES) - 64'd1) / 64'(WORD_BYTES));

	logic [ADDR_WIDTH-1:0] start_mem [MAX_BLOCKS];
	logic [ADDR_WIDTH-1:0] size_mem [MAX_BLOCKS];

	logic [ADDR_WIDTH-1:0] heap_start_q, heap_end_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q, shift_q;
	logic [ADDR_WIDTH-1:0] rd_start_q, rd_size_q, rd_next_q;
	logic [ADDR_WIDTH-1:0] size_q, target_q, gap_q;
	logic is_free_q, pre_fail_q;
	logic sh_valid_q;

	// Request preparation: round up, add header, region check.
	logic [ADDR_WIDTH:0] req_ext, pad, rnd, hs_hdr, sz_hdr;
	logic [31:0] req32, quo, rem;
	logic [64:0] prod;
	logic bad_region;
	always_comb begin
		req_ext = {1'b0, ADDR_WIDTH'(in_request)};
		req32 = 32'(req_ext);
		prod = 65'(req32) * 65'(RECIP);
		quo = 32'(prod >> WSH);
		rem = req32 - quo * 32'(WORD_BYTES);
		pad = (rem == '0) ? '0 : WRD - (ADDR_WIDTH+1)'(rem);
		rnd = req_ext + pad;
		sz_hdr = {1'b0, rnd[ADDR_WIDTH-1:0]} + HDR;
		hs_hdr = {1'b0, heap_start_q} + HDR;
		bad_region = hs_hdr[ADDR_WIDTH] || ({1'b0, heap_end_q} < hs_hdr);
	end

	// Walk evaluation.
	logic [ADDR_WIDTH:0] gap_sum, end_sum;
	logic [ADDR_WIDTH-1:0] limit;
	logic alloc_ok;
	assign gap_sum = {1'b0, rd_start_q} + {1'b0, rd_size_q};
	assign end_sum = {1'b0, gap_sum[ADDR_WIDTH-1:0]} + {1'b0, size_q};
	assign limit = stat.walk_last ? heap_end_q : rd_next_q;
	assign alloc_ok = !is_free_q && stat.fit && !stat.carry_fail && !pre_fail_q;

	logic [CW-1:0] idx_ext;
	assign idx_ext = CW'(idx_q);

	always_comb begin
		stat.is_free = is_free_q;
		stat.pre_fail = pre_fail_q;
		stat.walk_last = (idx_ext + 1'b1) >= count_q;
		stat.carry_fail = gap_sum[ADDR_WIDTH] || end_sum[ADDR_WIDTH];
		stat.fit = end_sum[ADDR_WIDTH-1:0] <= limit;
		stat.match = (idx_q != '0) && (rd_start_q == target_q);
		stat.shift_done = !sh_valid_q;
	end

	// Table memory. Reads at idx and idx+1 for the walk; a shift moves one
	// entry per cycle in the direction of the operation.
	logic [IW-1:0] idx_nx;
	assign idx_nx = idx_q + 1'b1;
	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_start_q <= (idx_q == '0) ? heap_start_q : start_mem[idx_q];
			rd_size_q <= (idx_q == '0) ? '0 : size_mem[idx_q];
			rd_next_q <= start_mem[idx_nx];
		end
		if (cmd.shift_issue) begin
			if (is_free_q) begin
				start_mem[shift_q] <= start_mem[IW'(shift_q + 1'b1)];
				size_mem[shift_q] <= size_mem[IW'(shift_q + 1'b1)];
			end else begin
				start_mem[shift_q] <= start_mem[IW'(shift_q - 1'b1)];
				size_mem[shift_q] <= size_mem[IW'(shift_q - 1'b1)];
			end
		end
		if (cmd.insert_wr) begin
			start_mem[idx_nx] <= gap_q;
			size_mem[idx_nx] <= size_q;
		end
		if (cmd.latch_req) begin
			size_q <= sz_hdr[ADDR_WIDTH-1:0];
			target_q <= ADDR_WIDTH'(in_release) - HDR[ADDR_WIDTH-1:0];
			is_free_q <= (in_cmd == CMD_FREE);
		end
		if (cmd.walk_step) gap_q <= gap_sum[ADDR_WIDTH-1:0];
		if (cmd.result_load) begin
			res_addr <= alloc_ok ? 32'(gap_sum[ADDR_WIDTH-1:0] + HDR[ADDR_WIDTH-1:0]) :
				32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_start_q <= '0;
			heap_end_q <= '0;
			count_q <= CW'(1);
			idx_q <= '0;
			shift_q <= '0;
			sh_valid_q <= 1'b0;
			pre_fail_q <= 1'b0;
			res_status <= ST_ALLOC_FAIL;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_HEAP_END) heap_end_q <= ADDR_WIDTH'(cfg_data);
				else heap_start_q <= ADDR_WIDTH'(cfg_data);
			end
			if (cmd.restore) count_q <= CW'(1);
			else if (cmd.count_inc) count_q <= count_q + 1'b1;
			else if (cmd.count_dec) count_q <= count_q - 1'b1;
			if (cmd.latch_req) begin
				idx_q <= '0;
				pre_fail_q <= (in_cmd == CMD_ALLOC) && (bad_region || rnd[ADDR_WIDTH] ||
					(rnd[ADDR_WIDTH-1:0] == '0) || sz_hdr[ADDR_WIDTH] ||
					(count_q >= CW'(MAX_BLOCKS)));
			end else if (cmd.walk_step && !cmd.result_load) begin
				idx_q <= idx_nx;
			end
			if (cmd.walk_step) begin
				// Entering a shift leaves the shift pointer ready.
				if (is_free_q) begin
					shift_q <= idx_q;
					sh_valid_q <= (idx_ext + 1'b1) < count_q;
				end else begin
					shift_q <= IW'(count_q);
					sh_valid_q <= count_q > (idx_ext + 1'b1);
				end
			end else if (cmd.shift_issue) begin
				if (is_free_q) begin
					shift_q <= shift_q + 1'b1;
					sh_valid_q <= (CW'(shift_q) + 2'd2) < count_q;
				end else begin
					shift_q <= shift_q - 1'b1;
					sh_valid_q <= (CW'(shift_q) - 1'b1) > (idx_ext + 1'b1);
				end
			end
			if (cmd.result_load) begin
				if (is_free_q) res_status <= stat.match ? ST_FREED : ST_FREE_IGNORED;
				else res_status <= alloc_ok ? ST_ALLOCATED : ST_ALLOC_FAIL;
			end
		end
	end
endmodule

FILE: rtl/ffha_ctrl.sv
module ffha_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input logic cfg_restore,
	input ffha_pkg::ffha_stat_t stat,
	output ffha_pkg::ffha_cmd_t cmd
);
	import ffha_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_EVAL  = 6'b000100,
		S_SHIFT = 6'b001000,
		S_DONE  = 6'b010000,
		S_FAIL  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;
	logic out_take;

	assign out_take = out_valid_q && out_ready;
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cmd.restore = cfg_restore;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.latch_req = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (!stat.is_free && stat.pre_fail) state_d = S_FAIL;
				else begin
					cmd.rd_issue = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.is_free) begin
					if (stat.match) begin
						cmd.walk_step = 1'b1;
						cmd.result_load = 1'b1;
						state_d = S_SHIFT;
					end else if (stat.walk_last) state_d = S_FAIL;
					else begin
						cmd.walk_step = 1'b1;
						state_d = S_READ;
					end
				end else if (stat.carry_fail) state_d = S_FAIL;
				else if (stat.fit) begin
					cmd.walk_step = 1'b1;
					cmd.result_load = 1'b1;
					state_d = S_SHIFT;
				end else if (stat.walk_last) state_d = S_FAIL;
				else begin
					cmd.walk_step = 1'b1;
					state_d = S_READ;
				end
			end
			S_SHIFT: begin
				if (!stat.shift_done) cmd.shift_issue = 1'b1;
				else begin
					if (stat.is_free) cmd.count_dec = 1'b1;
					else begin
						cmd.insert_wr = 1'b1;
						cmd.count_inc = 1'b1;
					end
					state_d = S_DONE;
				end
			end
			S_DONE: state_d = S_IDLE;
			S_FAIL: begin
				cmd.result_load = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE || state_q == S_FAIL) out_valid_q <= 1'b1;
			else if (out_take) out_valid_q <= 1'b0;
		end
	end
endmodule

FILE: rtl/first_fit_heap_allocator_core.sv
// First-fit heap allocator core.
// The in channel carries {cmd, request_bytes, release_addr}; cmd low asks for
// an allocate, cmd high frees an address once returned. Every transfer on in
// gives exactly one transfer on out, carrying block_addr and status.
// heap_start and heap_end are written through the plain write port, and only
// while the block is idle: the user must keep to that, as the block itself
// does not enforce it. Each write empties the table to the sentinel only.
// An allocate walks the address-ordered table, reading and then evaluating
// each entry, until a gap fits, then shifts later entries up by one, one
// entry per cycle; a free walks to the matching entry and shifts the rest
// down. Entry 0 is the sentinel. A rejected allocate skips the walk.
// One item is handled at a time. The result is held in an output register;
// the next item is taken in the cycle that result transfers or later, and a
// stalled receiver holds the block with its result waiting.
// Asynchronous reset restores heap_start and heap_end to zero and an empty
// table holding only the sentinel; no clearing pass is needed.
module first_fit_heap_allocator_core #(
	parameter int unsigned MAX_BLOCKS = 64,
	parameter int unsigned WORD_BYTES = 4,
	parameter int unsigned HEADER_BYTES = 8,
	parameter int unsigned ADDR_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	ffha_if.sink in_ch,
	ffha_if.source out_ch,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [31:0] cfg_data
);
	import ffha_pkg::*;

	ffha_cmd_t cmd;
	ffha_stat_t stat;
	logic [31:0] res_addr;
	logic [1:0] res_status;

	ffha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cfg_restore(cfg_we), .stat(stat), .cmd(cmd)
	);

	ffha_datapath #(
		.MAX_BLOCKS(MAX_BLOCKS), .WORD_BYTES(WORD_BYTES),
		.HEADER_BYTES(HEADER_BYTES), .ADDR_WIDTH(ADDR_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_idx(cfg_index),
		.cfg_data(cfg_data),
		.in_cmd(in_ch.data[64]), .in_request(in_ch.data[63:32]),
		.in_release(in_ch.data[31:0]),
		.res_addr(res_addr), .res_status(res_status)
	);

	assign out_ch.data = {res_addr, res_status};
endmodule

FILE: tb/sv/first_fit_heap_allocator_core_tb.sv
module first_fit_heap_allocator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	localparam int unsigned MAXB = 64;
	localparam int unsigned WORDB = 4;
	localparam int unsigned HDR = 8;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic cmd;
		logic [31:0] request_bytes;
		logic [31:0] release_addr;
	} req_t;

	typedef struct packed {
		logic [31:0] block_addr;
		status_t status;
	} rsp_t;

	// Allocator shadow: tracks the block table and queues the answers it predicts.
	class heap_scoreboard;
		logic [31:0] hs, he;
		logic [31:0] ent_start[MAXB];
		logic [31:0] ent_size[MAXB];
		int count;
		rsp_t pending[$];
		int mismatches;
		logic [31:0] live[$];

		function void restore();
			ent_start[0] = hs;
			ent_size[0] = 0;
			count = 1;
			live.delete();
		endfunction

		function void set_reg(logic [0:0] idx, logic [31:0] v);
			if (idx == REG_HEAP_START)
				hs = v;
			else
				he = v;
			restore();
		endfunction

		function rsp_t alloc(logic [31:0] req);
			rsp_t r;
			logic [32:0] s, g, e;
			logic [31:0] lim;
			r.block_addr = 0;
			r.status = ST_ALLOC_FAIL;
			s = {1'b0, hs} + HDR;
			if (s[32] || he < s[31:0])
				return r;
			s = {1'b0, req};
			if (req % WORDB != 0)
				s = s + (WORDB - req % WORDB);
			if (s[32] || s[31:0] == 0)
				return r;
			s = s + HDR;
			if (s[32] || count >= MAXB)
				return r;
			for (int i = 0; i < count; i++) begin
				g = {1'b0, ent_start[i]} + ent_size[i];
				if (g[32])
					return r;
				e = {1'b0, g[31:0]} + s[31:0];
				if (e[32])
					return r;
				lim = (i + 1 < count) ? ent_start[i + 1] : he;
				if (e[31:0] <= lim) begin
					for (int j = count; j > i + 1; j--) begin
						ent_start[j] = ent_start[j - 1];
						ent_size[j] = ent_size[j - 1];
					end
					ent_start[i + 1] = g[31:0];
					ent_size[i + 1] = s[31:0];
					count++;
					r.block_addr = g[31:0] + HDR;
					r.status = ST_ALLOCATED;
					live.push_back(r.block_addr);
					return r;
				end
			end
			return r;
		endfunction

		function rsp_t release_block(logic [31:0] a);
			rsp_t r;
			logic [31:0] t;
			r.block_addr = 0;
			r.status = ST_FREE_IGNORED;
			t = a - HDR;
			for (int i = 1; i < count; i++) begin
				if (ent_start[i] == t) begin
					for (int j = i; j + 1 < count; j++) begin
						ent_start[j] = ent_start[j + 1];
						ent_size[j] = ent_size[j + 1];
					end
					count--;
					r.status = ST_FREED;
					foreach (live[k])
						if (live[k] == a) begin
							live.delete(k);
							break;
						end
					return r;
				end
			end
			return r;
		endfunction

		function void note_request(req_t q);
			if (q.cmd == CMD_ALLOC)
				pending.push_back(alloc(q.request_bytes));
			else
				pending.push_back(release_block(q.release_addr));
		endfunction

		function void check_answer(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result addr=%h status=%0d",
						got.block_addr, got.status);
				return;
			end
			want = pending.pop_front();
			if (got.block_addr !== want.block_addr || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
						want.block_addr, want.status, got.block_addr, got.status);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [0:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	longint cycles = 0;
	int src_idle = 0;
	int snk_stall = 0;
	heap_scoreboard sb;

	ffha_if #(.W($bits(req_t))) in_ch ();
	ffha_if #(.W($bits(rsp_t))) out_ch ();

	first_fit_heap_allocator_core u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: checks each transfer and stalls at the current rate.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_answer(rsp_t'(out_ch.data));
			out_ch.ready <= ($urandom_range(99) >= snk_stall);
		end else begin
			out_ch.ready <= 1'b0;
		end
	end

	// Leaves valid high after the transfer; an idle step in the next send, or
	// the caller, lowers it.
	task automatic send(req_t q);
		while (src_idle > 0 && $urandom_range(99) < src_idle) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= q;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_request(q);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (3 * MAXB + 20) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic do_alloc(logic [31:0] n);
		req_t q;
		q.cmd = CMD_ALLOC;
		q.request_bytes = n;
		q.release_addr = $urandom;
		send(q);
	endtask

	task automatic do_free(logic [31:0] a);
		req_t q;
		q.cmd = CMD_FREE;
		q.request_bytes = $urandom;
		q.release_addr = a;
		send(q);
	endtask

	function automatic logic [31:0] rand_size();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(3);
			default: return $urandom_range(120);
		endcase
	endfunction

	task automatic random_items(int n);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: do_alloc(rand_size());
				5, 6, 7: begin
					if (sb.live.size() != 0)
						do_free(sb.live[$urandom_range(sb.live.size() - 1)]);
					else
						do_free($urandom);
				end
				8: do_free(sb.hs + $urandom_range(64));
				default: do_free($urandom);
			endcase
		end
	endtask

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		sb = new();
		sb.hs = 0;
		sb.he = 0;
		sb.restore();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset region is invalid, so allocates fail.
		do_alloc(4);
		do_free(8);
		drain();
		write_reg(REG_HEAP_START, 32'h0000_1000);
		write_reg(REG_HEAP_END, 32'h0000_1400);
		do_alloc(0);
		do_alloc(1);
		do_alloc(32'hFFFF_FFFF);
		do_alloc(32'hFFFF_FFF8);
		do_alloc(32'h7FFF_FFFF);
		do_alloc(5);
		do_alloc(16);
		do_free(32'h0000_1008);
		do_alloc(3);
		do_free(32'h0000_1008);
		do_free(32'h0000_1000);
		do_free(0);
		do_free(4);
		do_free(32'hFFFF_FFFF);
		do_alloc(2000);
		for (int k = 0; k < 8; k++)
			do_alloc(1);
		drain();
		// Region up against the top of the address space forces carries.
		write_reg(REG_HEAP_START, 32'hFFFF_FF00);
		write_reg(REG_HEAP_END, 32'hFFFF_FFFF);
		do_alloc(100);
		do_alloc(200);
		do_alloc(4);
		drain();
		write_reg(REG_HEAP_START, 32'hFFFF_FFFC);
		do_alloc(4);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			src_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 81 : 36) : 0;
			snk_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 81 : 36) : 0;
			case (ph)
				0: begin
					write_reg(REG_HEAP_START, 32'h0000_0000);
					write_reg(REG_HEAP_END, 32'h0000_2000);
				end
				1: begin
					write_reg(REG_HEAP_START, $urandom & 32'h7FFF_FFF0);
					write_reg(REG_HEAP_END, sb.hs + $urandom_range(600, 5000));
				end
				2: begin
					write_reg(REG_HEAP_START, 32'h8000_0000);
					write_reg(REG_HEAP_END, 32'hFFFF_FFFF);
				end
				default: begin
					write_reg(REG_HEAP_START, $urandom);
					write_reg(REG_HEAP_END, $urandom);
				end
			endcase
			random_items(120);
			// Let every result arrive before the next transfer.
			in_ch.valid <= 0;
			while (sb.pending.size() != 0)
				@(posedge clk);
			random_items(16);
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
